### hw/rtl/iiea_pkg.sv
package iiea_pkg;

	// Command codes carried by the cmd field; code seven is a no-op.
	typedef enum logic [2:0] {
		CMD_READ   = 3'd0,
		CMD_WRITE  = 3'd1,
		CMD_INSERT = 3'd2,
		CMD_ERASE  = 3'd3,
		CMD_FIND   = 3'd4,
		CMD_RESIZE = 3'd5,
		CMD_CLEAR  = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ERR_OK       = 2'd0,
		ERR_RANGE    = 2'd1,
		ERR_CAPACITY = 2'd2
	} err_t;

	localparam int WORD_W   = 32;
	// Fan-in of one match tree node.
	localparam int FAN_BITS = 4;
	localparam int FAN      = 1 << FAN_BITS;

	// Broadcast from the controller to every cell in the chain.
	typedef struct packed {
		logic load;
		logic write;
		logic insert;
		logic erase;
		logic read;
		logic find;
	} cell_ctl_t;

endpackage

### hw/rtl/iiea_cell.sv
module iiea_cell #(
	parameter int IW  = 9,
	parameter int POS = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  iiea_pkg::cell_ctl_t               ctl,
	input  logic [IW-1:0]                     idx,
	input  logic [IW-1:0]                     count,
	input  logic [iiea_pkg::WORD_W-1:0]       value,
	input  logic [iiea_pkg::WORD_W-1:0]       left,
	input  logic [iiea_pkg::WORD_W-1:0]       right,
	output logic [iiea_pkg::WORD_W-1:0]       word,
	output logic                              hit
);

	localparam logic [IW-1:0] POS_L  = IW'(POS);
	localparam logic [IW-1:0] POS_UP = IW'(POS + 1);

	logic [iiea_pkg::WORD_W-1:0] word_q;
	logic [iiea_pkg::WORD_W-1:0] word_nxt;
	logic                        hit_q;
	logic                        hit_nxt;

	always_comb begin
		word_nxt = word_q;
		if (ctl.write && POS_L == idx) begin
			word_nxt = value;
		end
		if (ctl.insert) begin
			if (POS_L == idx) begin
				word_nxt = value;
			end else if (POS_L > idx && POS_L <= count) begin
				word_nxt = left;
			end
		end
		if (ctl.erase && POS_L >= idx && POS_UP < count) begin
			word_nxt = right;
		end
	end

	// Hit is sampled against the words as they stand before this item.
	assign hit_nxt = (ctl.read && POS_L == idx) ||
		(ctl.find && POS_L < count && word_q == value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else begin
			word_q <= word_nxt;
		end
	end

	// Hold the hit flag for the whole tree walk.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			hit_q <= hit_nxt;
		end
	end

	assign word = word_q;
	assign hit  = hit_q;

endmodule

### hw/rtl/iiea_node.sv
module iiea_node #(
	parameter int IXW = 8
) (
	input  logic                                               clk,
	input  logic [iiea_pkg::FAN-1:0]                           kid_any,
	input  logic [iiea_pkg::FAN-1:0][IXW-1:0]                  kid_idx,
	input  logic [iiea_pkg::FAN-1:0][iiea_pkg::WORD_W-1:0]     kid_data,
	output logic                                               any,
	output logic [IXW-1:0]                                     idx,
	output logic [iiea_pkg::WORD_W-1:0]                        data
);

	localparam int HALF = iiea_pkg::FAN / 2;

	logic                        lo_any, hi_any;
	logic [IXW-1:0]              lo_idx, hi_idx;
	logic [iiea_pkg::WORD_W-1:0] lo_data, hi_data;
	logic                        any_q;
	logic [IXW-1:0]              idx_q;
	logic [iiea_pkg::WORD_W-1:0] data_q;

	// Pick the lowest hit in each half, then prefer the lower half.
	always_comb begin
		lo_any  = 1'b0;
		lo_idx  = kid_idx[0];
		lo_data = kid_data[0];
		hi_any  = 1'b0;
		hi_idx  = kid_idx[HALF];
		hi_data = kid_data[HALF];
		for (int k = HALF - 1; k >= 0; k--) begin
			if (kid_any[k]) begin
				lo_any  = 1'b1;
				lo_idx  = kid_idx[k];
				lo_data = kid_data[k];
			end
			if (kid_any[k + HALF]) begin
				hi_any  = 1'b1;
				hi_idx  = kid_idx[k + HALF];
				hi_data = kid_data[k + HALF];
			end
		end
	end

	always_ff @(posedge clk) begin
		any_q  <= lo_any | hi_any;
		idx_q  <= lo_any ? lo_idx : hi_idx;
		data_q <= lo_any ? lo_data : hi_data;
	end

	assign any  = any_q;
	assign idx  = idx_q;
	assign data = data_q;

endmodule

### hw/rtl/indexed_insert_erase_array_unit.sv
// Path: accept loads the cells and the pending slot, then the output register; read
// and find first walk the registered match tree that reduces the cell hits.
// Throughput: one word per cycle for the mutating commands while the output is not
// stalled; no new item is taken until a read or find has walked that tree.
// Reset: arst_n clears every stored word, the length and the handshake state at once.
module indexed_insert_erase_array_unit #(
	parameter int CAPACITY = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic [2:0]                          cmd,
	input  logic [$clog2(CAPACITY+1)-1:0]       index,
	input  logic signed [31:0]                  value,
	input  logic [$clog2(CAPACITY+1)-1:0]       resize_len,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic signed [31:0]                  read_value,
	output logic signed [$clog2(CAPACITY):0]    found_index,
	output logic [$clog2(CAPACITY+1)-1:0]       length,
	output logic [1:0]                          error
);

	// Width of lengths and positions, and of the signed found index.
	localparam int IW     = $clog2(CAPACITY + 1);
	localparam int FW     = $clog2(CAPACITY) + 1;
	// Match tree: radix-FAN levels over the padded cell row.
	localparam int LEVELS = ($clog2(CAPACITY) + iiea_pkg::FAN_BITS - 1) / iiea_pkg::FAN_BITS;
	localparam int IXW    = LEVELS * iiea_pkg::FAN_BITS;
	localparam int PAD    = 1 << IXW;
	localparam int CW     = $clog2(LEVELS + 1);
	localparam logic [IW-1:0] CAP_L = IW'(CAPACITY);
	localparam logic [CW-1:0] WALK  = CW'(LEVELS);

	logic [IW-1:0]       count_q;
	logic [IW-1:0]       count_nxt;
	logic [1:0]          err_nxt;
	iiea_pkg::cell_ctl_t ctl;
	logic                accept;
	logic                finish;

	// Pending item: result fields known at accept, tree ones come later.
	logic                pend_q;
	logic [CW-1:0]       cnt_q;
	logic                p_read_q;
	logic                p_find_q;
	logic [IW-1:0]       p_len_q;
	logic [1:0]          p_err_q;

	logic                        res_valid_q;
	logic [31:0]                 read_value_q;
	logic [FW-1:0]               found_index_q;
	logic [IW-1:0]               length_q;
	logic [1:0]                  error_q;

	logic [iiea_pkg::WORD_W-1:0] words [CAPACITY];
	logic [CAPACITY-1:0]         hits;

	logic [LEVELS:0][PAD-1:0]                           lv_any;
	logic [PAD-1:0][IXW-1:0]                            lv_idx  [LEVELS+1];
	logic [PAD-1:0][iiea_pkg::WORD_W-1:0]               lv_data [LEVELS+1];

	logic                        top_any;
	logic [IXW-1:0]              top_idx;
	logic [iiea_pkg::WORD_W-1:0] top_data;

	assign finish     = pend_q && cnt_q == '0 && (!res_valid_q || res_ready);
	assign item_ready = !pend_q || finish;
	assign accept     = item_valid && item_ready;

	// Decode the command: bound checks, new length, cell strobes.
	always_comb begin
		count_nxt = count_q;
		err_nxt   = iiea_pkg::ERR_OK;
		ctl       = '0;
		ctl.load  = accept;
		case (iiea_pkg::cmd_t'(cmd))
			iiea_pkg::CMD_READ: begin
				if (index < count_q) begin
					ctl.read = accept;
				end else begin
					err_nxt = iiea_pkg::ERR_RANGE;
				end
			end
			iiea_pkg::CMD_WRITE: begin
				if (index < count_q) begin
					ctl.write = accept;
				end else begin
					err_nxt = iiea_pkg::ERR_RANGE;
				end
			end
			iiea_pkg::CMD_INSERT: begin
				if (index > count_q) begin
					err_nxt = iiea_pkg::ERR_RANGE;
				end else if (count_q >= CAP_L) begin
					err_nxt = iiea_pkg::ERR_CAPACITY;
				end else begin
					ctl.insert = accept;
					count_nxt  = count_q + 1'b1;
				end
			end
			iiea_pkg::CMD_ERASE: begin
				if (index >= count_q) begin
					err_nxt = iiea_pkg::ERR_RANGE;
				end else begin
					ctl.erase = accept;
					count_nxt = count_q - 1'b1;
				end
			end
			iiea_pkg::CMD_FIND: begin
				ctl.find = accept;
			end
			iiea_pkg::CMD_RESIZE: begin
				if (resize_len > CAP_L) begin
					err_nxt = iiea_pkg::ERR_CAPACITY;
				end else begin
					count_nxt = resize_len;
				end
			end
			iiea_pkg::CMD_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	// The cell row: each cell sees its lower and upper neighbor.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [iiea_pkg::WORD_W-1:0] left_w, right_w;
		if (i == 0) begin : g_lo
			assign left_w = '0;
		end else begin : g_lo
			assign left_w = words[i-1];
		end
		if (i == CAPACITY - 1) begin : g_hi
			assign right_w = '0;
		end else begin : g_hi
			assign right_w = words[i+1];
		end
		iiea_cell #(.IW(IW), .POS(i)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.idx   (index),
			.count (count_q),
			.value (value),
			.left  (left_w),
			.right (right_w),
			.word  (words[i]),
			.hit   (hits[i])
		);
	end

	// Tree leaves: one per cell, padding slots never hit.
	for (genvar i = 0; i < PAD; i++) begin : g_leaf
		assign lv_idx[0][i] = IXW'(i);
		if (i < CAPACITY) begin : g_used
			assign lv_any[0][i]  = hits[i];
			assign lv_data[0][i] = words[i];
		end else begin : g_pad
			assign lv_any[0][i]  = 1'b0;
			assign lv_data[0][i] = '0;
		end
	end

	for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
		for (genvar j = 0; j < (PAD >> (iiea_pkg::FAN_BITS * (l + 1))); j++) begin : g_nd
			iiea_node #(.IXW(IXW)) u_node (
				.clk     (clk),
				.kid_any (lv_any[l][j*iiea_pkg::FAN +: iiea_pkg::FAN]),
				.kid_idx (lv_idx[l][j*iiea_pkg::FAN +: iiea_pkg::FAN]),
				.kid_data(lv_data[l][j*iiea_pkg::FAN +: iiea_pkg::FAN]),
				.any     (lv_any[l+1][j]),
				.idx     (lv_idx[l+1][j]),
				.data    (lv_data[l+1][j])
			);
		end
	end

	assign top_any  = lv_any[LEVELS][0];
	assign top_idx  = lv_idx[LEVELS][0];
	assign top_data = lv_data[LEVELS][0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			pend_q   <= 1'b0;
			cnt_q    <= '0;
			p_read_q <= 1'b0;
			p_find_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q  <= count_nxt;
				pend_q   <= 1'b1;
				// Walk the tree only when the cells hold something to report.
				cnt_q    <= (ctl.read || ctl.find) ? WALK : '0;
				p_read_q <= ctl.read;
				p_find_q <= ctl.find;
			end else begin
				if (finish) begin
					pend_q <= 1'b0;
				end
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Fields fixed at accept; no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			p_len_q <= count_nxt;
			p_err_q <= err_nxt;
		end
	end

	// Output register: takes the pending item when empty or when its result is being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (finish) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			read_value_q  <= p_read_q ? top_data : '0;
			found_index_q <= (p_find_q && top_any) ? {1'b0, top_idx[FW-2:0]} : '1;
			length_q      <= p_len_q;
			error_q       <= p_err_q;
		end
	end

	assign res_valid   = res_valid_q;
	assign read_value  = read_value_q;
	assign found_index = found_index_q;
	assign length      = length_q;
	assign error       = error_q;

	// A walk in progress blocks new words.
	a_walk_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q && cnt_q != '0 |-> !item_ready)
		else $error("item taken during tree walk");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_L)
		else $error("length above capacity");

	// A checked read always has exactly one cell answering.
	a_read_hit: assert property (@(posedge clk) disable iff (!arst_n)
		finish && p_read_q |-> top_any)
		else $error("read finished without a hit");

	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> res_valid)
		else $error("finished item not presented");

endmodule
